FILE: src/psbs_pkg.sv
`default_nettype none

package psbs_pkg;

	localparam int MaxElements = 1024;
	localparam int AddrW       = $clog2(MaxElements);
	localparam int CountW      = $clog2(MaxElements + 1);
	localparam int DataW       = 32;
	localparam int PaddrW      = 3;

	// register index, taken from paddr[2]
	localparam logic RegTargetSum = 1'b0;

	typedef logic [DataW-1:0] data_t;
	typedef logic [AddrW-1:0] addr_t;
	typedef logic [CountW-1:0] count_t;

endpackage

`default_nettype wire

FILE: src/pair_sum_brute_search.sv
`default_nettype none

// Brute-force pair-sum search. Elements stream in one per cycle, while
// in_stall is low, into a 1024-entry store; the transaction flagged
// last_element starts a search of every pair i<j for a 33-bit sum equal to
// target_sum, stopping at the first hit. One result transaction per set
// carries pair_found and set_overflow (elements past 1024 are dropped).
// During the search and while the result waits, in_stall is high. All pair
// sums go through one adder/comparator fed by the single store read port:
// each row i reads a[i], scans j from i+1 to n-1, then drains the pipeline;
// sets of fewer than two elements go straight to the result.
// The store is not cleared at reset.
module pair_sum_brute_search (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [psbs_pkg::PaddrW-1:0]   paddr,
	input  wire logic [31:0]                   pwdata,
	output logic      [31:0]                   prdata,
	output logic                               pready,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic signed [psbs_pkg::DataW-1:0] element_value,
	input  wire logic                          last_element,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               pair_found,
	output logic                               set_overflow
);

	typedef enum logic [2:0] {
		S_LOAD,
		S_START,
		S_ROW,
		S_A_WAIT,
		S_SCAN,
		S_DRAIN,
		S_OUT
	} state_t;

	state_t           state_q;
	psbs_pkg::data_t  target_q;
	psbs_pkg::count_t cnt_q;
	logic             ovf_q;
	logic             found_q;
	psbs_pkg::addr_t  i_q;
	psbs_pkg::addr_t  j_q;
	psbs_pkg::data_t  a_q;
	logic             v_s1;
	logic             hit_s2;
	logic             out_valid_q;
	logic             pair_found_q;
	logic             set_overflow_q;

	psbs_pkg::addr_t  raddr;
	psbs_pkg::data_t  rdata;
	logic             in_accept;
	logic             full;
	logic             we;
	logic             out_free;

	// configuration
	assign pready = 1'b1;
	assign prdata = (paddr[2] == psbs_pkg::RegTargetSum) ? target_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
		end else if (psel && penable && pwrite && pready
				&& paddr[2] == psbs_pkg::RegTargetSum) begin
			target_q <= pwdata;
		end
	end

	assign in_stall  = (state_q != S_LOAD);
	assign in_accept = in_valid && !in_stall;
	assign full      = (cnt_q == psbs_pkg::CountW'(psbs_pkg::MaxElements));
	assign we        = in_accept && !full;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		case (state_q)
			S_SCAN:  raddr = j_q;
			default: raddr = i_q;
		endcase
	end

	psbs_ram #(
		.Depth(psbs_pkg::MaxElements),
		.Width(psbs_pkg::DataW)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(cnt_q[psbs_pkg::AddrW-1:0]),
		.wdata(element_value),
		.raddr(raddr),
		.rdata(rdata)
	);

	psbs_match u_match (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid_s1(v_s1),
		.a       (a_q),
		.b       (rdata),
		.target  (target_q),
		.hit_s2  (hit_s2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_LOAD;
			cnt_q          <= '0;
			ovf_q          <= 1'b0;
			found_q        <= 1'b0;
			i_q            <= '0;
			j_q            <= '0;
			v_s1           <= 1'b0;
			out_valid_q    <= 1'b0;
			pair_found_q   <= 1'b0;
			set_overflow_q <= 1'b0;
		end else begin
			v_s1 <= (state_q == S_SCAN) && !hit_s2;
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_LOAD: begin
					if (in_accept) begin
						if (full) begin
							ovf_q <= 1'b1;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
						if (last_element) begin
							state_q <= S_START;
						end
					end
				end
				S_START: begin
					i_q <= '0;
					if (cnt_q < psbs_pkg::CountW'(2)) begin
						found_q <= 1'b0;
						state_q <= S_OUT;
					end else begin
						state_q <= S_ROW;
					end
				end
				S_ROW: begin
					state_q <= S_A_WAIT;
				end
				S_A_WAIT: begin
					j_q     <= i_q + 1'b1;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (hit_s2) begin
						found_q <= 1'b1;
						state_q <= S_OUT;
					end else begin
						j_q  <= j_q + 1'b1;
						if ({1'b0, j_q} + 1'b1 == cnt_q) begin
							state_q <= S_DRAIN;
						end
					end
				end
				S_DRAIN: begin
					if (hit_s2) begin
						found_q <= 1'b1;
						state_q <= S_OUT;
					end else if (!v_s1) begin
						if ({1'b0, i_q} + psbs_pkg::CountW'(2) == cnt_q) begin
							found_q <= 1'b0;
							state_q <= S_OUT;
						end else begin
							i_q     <= i_q + 1'b1;
							state_q <= S_ROW;
						end
					end
				end
				S_OUT: begin
					if (out_free) begin
						pair_found_q   <= found_q;
						set_overflow_q <= ovf_q;
						cnt_q          <= '0;
						ovf_q          <= 1'b0;
						state_q        <= S_LOAD;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_A_WAIT) begin
			a_q <= rdata;
		end
	end

	assign out_valid    = out_valid_q;
	assign pair_found   = pair_found_q;
	assign set_overflow = set_overflow_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= psbs_pkg::CountW'(psbs_pkg::MaxElements))
		else $error("element count past capacity");

	a_scan_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> j_q > i_q)
		else $error("scan index not past row index");

	a_hit_needs_compare: assert property (@(posedge clk) disable iff (!arst_n)
		hit_s2 |-> $past(v_s1))
		else $error("match without a compare issued");

	a_result_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_OUT))
		else $error("result transaction outside output state");

endmodule

`default_nettype wire

FILE: src/psbs_ram.sv
`default_nettype none

module psbs_ram #(
	parameter int Depth = 1024,
	parameter int Width = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: src/psbs_match.sv
`default_nettype none

// 33-bit pair sum against the target, result registered
module psbs_match (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           valid_s1,
	input  wire psbs_pkg::data_t a,
	input  wire psbs_pkg::data_t b,
	input  wire psbs_pkg::data_t target,
	output logic                hit_s2
);

	logic [psbs_pkg::DataW:0] sum;
	logic [psbs_pkg::DataW:0] goal;

	assign sum  = {a[psbs_pkg::DataW-1], a} + {b[psbs_pkg::DataW-1], b};
	assign goal = {target[psbs_pkg::DataW-1], target};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_s2 <= 1'b0;
		end else begin
			hit_s2 <= valid_s1 && (sum == goal);
		end
	end

endmodule

`default_nettype wire
